>>> hdl/lcc_pkg.sv
// Shared types, constants and class decode for the card number checker.
package lcc_pkg;

    localparam int BIN_W          = 63;
    localparam int BCD_DIGITS     = 19;
    localparam int BCD_W          = 4 * BCD_DIGITS;
    localparam int CONV_STEPS     = BIN_W;
    localparam int CNT_W          = $clog2(CONV_STEPS);
    localparam int COUNT_W        = 5;
    localparam int CLASS_W        = 2;
    localparam int MAX_DIGITS_DEF = 19;

    localparam logic [COUNT_W-1:0] LEN_13 = COUNT_W'(13);
    localparam logic [COUNT_W-1:0] LEN_15 = COUNT_W'(15);
    localparam logic [COUNT_W-1:0] LEN_16 = COUNT_W'(16);

    typedef enum logic [CLASS_W-1:0] {
        CLASS_NONE    = 2'd0,
        CLASS_LEN15   = 2'd1,
        CLASS_LEAD4   = 2'd2,
        CLASS_PFX5X   = 2'd3
    } card_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_LOAD,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } unit_ctrl_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [3:0]         lead;
        logic [3:0]         second;
        logic               sum_zero;
        logic               overflow;
    } scan_res_t;

    function automatic card_class_t lcc_classify(input scan_res_t r);
        card_class_t cls;
        cls = CLASS_NONE;
        if (r.sum_zero && !r.overflow) begin
            if (r.count == LEN_15 && r.lead == 4'd3 &&
                (r.second == 4'd4 || r.second == 4'd7))
            begin
                cls = CLASS_LEN15;
            end
            else if ((r.count == LEN_13 || r.count == LEN_16) && r.lead == 4'd4) begin
                cls = CLASS_LEAD4;
            end
            else if (r.count == LEN_16 && r.lead == 4'd5 &&
                     r.second >= 4'd1 && r.second <= 4'd5)
            begin
                cls = CLASS_PFX5X;
            end
        end
        return cls;
    endfunction

endpackage

>>> hdl/lcc_bcd_conv.sv
// Shift-and-add-3 binary to BCD converter, one input bit per step.
module lcc_bcd_conv
    import lcc_pkg::*;
(
    input  logic             clk,
    input  unit_ctrl_t       ctrl,
    input  logic [BIN_W-1:0] bin_in,
    output logic [BCD_W-1:0] bcd
);

    logic [BIN_W-1:0] bin_reg;
    logic [BIN_W-1:0] bin_next;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [BCD_W-1:0] adj;

    always_comb
    begin
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
                adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            else
                adj[4*k +: 4] = bcd_reg[4*k +: 4];
        end
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctrl.load)
        begin
            bin_next = bin_in;
            bcd_next = '0;
        end
        else if (ctrl.step)
        begin
            bin_next = {bin_reg[BIN_W-2:0], 1'b0};
            bcd_next = {adj[BCD_W-2:0], bin_reg[BIN_W-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign bcd = bcd_reg;

endmodule

>>> hdl/lcc_digit_scan.sv
// Digit scanner: Luhn sum mod ten, digit count and leading digits, one digit per step.
module lcc_digit_scan
    import lcc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic             clk,
    input  unit_ctrl_t       ctrl,
    input  logic [BCD_W-1:0] bcd,
    output scan_res_t        res
);

    localparam int IDX_W = $clog2(MAX_DIGITS);

    logic [BCD_W-1:0]   shift_reg, shift_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [3:0]         sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [3:0]         prev_reg, prev_next;
    logic [3:0]         lead_reg, lead_next;
    logic [3:0]         second_reg, second_next;
    logic [3:0]         d;
    logic [4:0]         dbl;
    logic [4:0]         term;
    logic [4:0]         acc;

    always_comb
    begin
        d    = shift_reg[3:0];
        dbl  = {d, 1'b0};
        // fold a doubled digit above nine into its digit sum
        if (idx_reg[0])
            term = (dbl > 5'd9) ? dbl - 5'd9 : dbl;
        else
            term = {1'b0, d};
        acc = {1'b0, sum_reg} + term;
        if (acc >= 5'd10)
            acc = acc - 5'd10;

        shift_next  = shift_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        prev_next   = prev_reg;
        lead_next   = lead_reg;
        second_next = second_reg;
        if (ctrl.load)
        begin
            shift_next  = bcd;
            idx_next    = '0;
            sum_next    = '0;
            count_next  = COUNT_W'(1);
            prev_next   = '0;
            lead_next   = '0;
            second_next = '0;
        end
        else if (ctrl.step)
        begin
            shift_next = {4'd0, shift_reg[BCD_W-1:4]};
            idx_next   = idx_reg + 1'b1;
            sum_next   = acc[3:0];
            prev_next  = d;
            if (d != 4'd0)
            begin
                count_next  = COUNT_W'(idx_reg) + COUNT_W'(1);
                lead_next   = d;
                second_next = prev_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg  <= shift_next;
        idx_reg    <= idx_next;
        sum_reg    <= sum_next;
        count_reg  <= count_next;
        prev_reg   <= prev_next;
        lead_reg   <= lead_next;
        second_reg <= second_next;
    end

    // digits left over after the scan mean the number is too long
    always_comb
    begin
        res.overflow = (shift_reg != '0);
        res.count    = res.overflow ? COUNT_W'(MAX_DIGITS) : count_reg;
        res.lead     = lead_reg;
        res.second   = second_reg;
        res.sum_zero = (sum_reg == 4'd0);
    end

endmodule

>>> hdl/luhn_card_classifier.sv
// Top level: sequencer around the BCD converter and the Luhn digit scanner.
//
// Usage: drive card_number and pulse start while busy is low; the word is
// taken at that clock edge. busy then stays high while the block works.
// The converter turns the 63-bit number into BCD, one bit per cycle, a
// load state then loads the digit scanner, the scanner walks MAX_DIGITS
// digits one per cycle, and a final state classifies. done pulses for one
// cycle in the first cycle with busy low, with card_class, checksum_ok and
// digit_count valid from that cycle until the next word is classified. A new
// start may be given in the done cycle; no new word is taken while busy is
// high, and most of the busy time is spent in the bit-serial converter.
// The receiver cannot stall: done is a strobe and is not held.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and clears
// done; any word in flight is dropped.
// card_class: 0 invalid, 1 fifteen digits with prefix 34 or 37, 2 thirteen
// or sixteen digits led by 4, 3 sixteen digits with prefix 51 to 55. A
// nonzero class is given only with a good checksum.
module luhn_card_classifier
    import lcc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [BIN_W-1:0]   card_number,
    output logic               busy,
    output logic               done,
    output logic [CLASS_W-1:0] card_class,
    output logic               checksum_ok,
    output logic [COUNT_W-1:0] digit_count
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [CLASS_W-1:0] class_reg, class_next;
    logic               ok_reg, ok_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    unit_ctrl_t         conv_ctrl;
    unit_ctrl_t         scan_ctrl;
    logic [BCD_W-1:0]   bcd;
    scan_res_t          res;

    lcc_bcd_conv u_conv
    (
        .clk    (clk),
        .ctrl   (conv_ctrl),
        .bin_in (card_number),
        .bcd    (bcd)
    );

    lcc_digit_scan #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_scan
    (
        .clk  (clk),
        .ctrl (scan_ctrl),
        .bcd  (bcd),
        .res  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        class_reg <= class_next;
        ok_reg    <= ok_next;
        count_reg <= count_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        class_next = class_reg;
        ok_next    = ok_reg;
        count_next = count_reg;
        conv_ctrl  = '0;
        scan_ctrl  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    conv_ctrl.load = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_CONV;
                end
            end
            ST_CONV:
            begin
                conv_ctrl.step = 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CONV_STEPS - 1))
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                scan_ctrl.load = 1'b1;
                cnt_next       = '0;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                scan_ctrl.step = 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAX_DIGITS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                class_next = lcc_classify(res);
                ok_next    = res.sum_zero;
                count_next = res.count;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign card_class  = class_reg;
    assign checksum_ok = ok_reg;
    assign digit_count = count_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_from_classify: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_DONE))
        else $error("result strobe without a classify cycle");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (digit_count >= COUNT_W'(1) && digit_count <= COUNT_W'(MAX_DIGITS)))
        else $error("digit count out of range");

    a_class_needs_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (done && card_class != CLASS_NONE) |-> checksum_ok)
        else $error("card class given with a bad checksum");

endmodule
